// ----- rtl/alsd_pkg.sv -----
`timescale 1ns / 1ps

package alsd_pkg;

  // buffer limit and field widths
  localparam int MAX_SAMPLES = 4096;
  localparam int SMP_W    = 16;
  localparam int CNT_W    = 13;
  localparam int SUM_W    = 28;
  localparam int SQ_W     = 43;
  localparam int PEAK_W   = 15;
  localparam int THR_W    = 31;
  localparam int DB_W     = 16;
  localparam int RMS_W    = 16;
  localparam int CVS_W    = 46;
  localparam int CDB_W    = 33;
  localparam int CB_W     = 16;
  localparam int CFG_W    = 31;
  localparam int IDX_W    = 2;

  // arithmetic unit widths
  localparam int PROD_W   = 55;
  localparam int MUL_B_W  = 28;
  localparam int MUL_P_W  = 64;
  localparam int DIV_N_W  = 64;
  localparam int DIV_D_W  = 25;
  localparam int SQRT_X_W = 32;
  localparam int SQRT_R_W = 16;
  localparam int V_W      = 60;
  localparam int V_SHIFT  = 17;
  localparam int E_W      = 6;
  localparam int FRAC_W   = 16;
  localparam int LOG_W    = E_W + FRAC_W;
  localparam int DBP_W    = 42;

  localparam logic [CNT_W-1:0]   MAX_CNT    = CNT_W'(MAX_SAMPLES);
  localparam logic [MUL_B_W-1:0] AMP_SCALE  = MUL_B_W'(1250);
  localparam logic [CB_W-1:0]    CB_FULL    = CB_W'(65535);
  localparam logic [E_W-1:0]     E_START    = E_W'(V_W - 1);
  localparam int                 LOG_REF    = 46 * 65536;
  localparam int                 DB_PER_OCT = 197283;
  localparam int                 LOG_STEPS  = FRAC_W;

  typedef enum logic [IDX_W-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_NOISE     = 2'd1,
    REG_CALIBRATE = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    MUL_NS  = 2'd0,
    MUL_SS  = 2'd1,
    MUL_NN  = 2'd2,
    MUL_AMP = 2'd3
  } mul_sel_t;

  typedef enum logic [2:0] {
    DIV_VAR = 3'd0,
    DIV_V   = 3'd1,
    DIV_AMP = 3'd2,
    DIV_THR = 3'd3,
    DIV_CDB = 3'd4
  } div_sel_t;

  typedef enum logic {
    SQRT_RMS = 1'b0,
    SQRT_AMP = 1'b1
  } sqrt_sel_t;

  // controller to datapath
  typedef struct packed {
    logic      accept;
    logic      mul_start;
    mul_sel_t  mul_sel;
    logic      div_start;
    div_sel_t  div_sel;
    logic      sqrt_start;
    sqrt_sel_t sqrt_sel;
    logic      norm_shift;
    logic      log_init;
    logic      log_mul;
    logic      log_adj;
    logic      db_mul;
    logic      db_fin;
    logic      cal_acc;
    logic      finish;
  } alsd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic buf_end;
    logic mul_done;
    logic div_done;
    logic sqrt_done;
    logic v_zero;
    logic norm_done;
    logic cb_zero;
  } alsd_stat_t;

endpackage

// ----- rtl/alsd_mul.sv -----
`timescale 1ns / 1ps

module alsd_mul import alsd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [MUL_P_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  output logic               done,
  output logic [MUL_P_W-1:0] p
);

  localparam int CW = $clog2(MUL_B_W);

  logic [MUL_P_W-1:0] a_r;
  logic [MUL_B_W-1:0] b_r;
  logic [CW-1:0]      left;
  logic               run;

  // shift-add, one multiplier bit per cycle, msb first
  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && run && (left == '0);
      if (start) begin
        a_r  <= a;
        b_r  <= b;
        p    <= '0;
        left <= CW'(MUL_B_W - 1);
        run  <= 1'b1;
      end else if (run) begin
        p   <= (p << 1) + (b_r[MUL_B_W-1] ? a_r : '0);
        b_r <= b_r << 1;
        if (left == '0) begin
          run  <= 1'b0;
        end else begin
          left <= left - 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/alsd_div.sv -----
`timescale 1ns / 1ps

module alsd_div import alsd_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DIV_N_W-1:0] n,
  input  logic [DIV_D_W-1:0] d,
  output logic               done,
  output logic [DIV_N_W-1:0] q,
  output logic [DIV_D_W-1:0] r
);

  localparam int CW = $clog2(DIV_N_W);

  logic [DIV_D_W-1:0] d_r;
  logic [CW-1:0]      left;
  logic               run;
  logic [DIV_D_W:0]   rem_sh;
  logic               ge;

  // restoring step
  always_comb begin
    rem_sh = {r, q[DIV_N_W-1]};
    ge     = rem_sh >= {1'b0, d_r};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && run && (left == '0);
      if (start) begin
        q    <= n;
        r    <= '0;
        d_r  <= d;
        left <= CW'(DIV_N_W - 1);
        run  <= 1'b1;
      end else if (run) begin
        r <= ge ? DIV_D_W'(rem_sh - {1'b0, d_r}) : rem_sh[DIV_D_W-1:0];
        q <= {q[DIV_N_W-2:0], ge};
        if (left == '0) begin
          run  <= 1'b0;
        end else begin
          left <= left - 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/alsd_sqrt.sv -----
`timescale 1ns / 1ps

module alsd_sqrt import alsd_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [SQRT_X_W-1:0] x,
  output logic                done,
  output logic [SQRT_R_W-1:0] root
);

  localparam int CW    = $clog2(SQRT_R_W);
  localparam int REM_W = SQRT_R_W + 2;

  logic [SQRT_X_W-1:0] x_r;
  logic [REM_W-1:0]    rem;
  logic [REM_W+1:0]    rem_sh;
  logic [REM_W+1:0]    trial;
  logic                ge;
  logic [CW-1:0]       left;
  logic                run;

  // one result bit per cycle, two radicand bits in
  always_comb begin
    rem_sh = {rem, x_r[SQRT_X_W-1 -: 2]};
    trial  = (REM_W + 2)'({root, 2'b01});
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && run && (left == '0);
      if (start) begin
        x_r  <= x;
        rem  <= '0;
        root <= '0;
        left <= CW'(SQRT_R_W - 1);
        run  <= 1'b1;
      end else if (run) begin
        x_r  <= x_r << 2;
        rem  <= ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
        root <= {root[SQRT_R_W-2:0], ge};
        if (left == '0) begin
          run  <= 1'b0;
        end else begin
          left <= left - 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/alsd_dp.sv -----
`timescale 1ns / 1ps

module alsd_dp import alsd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  alsd_cmd_t               cmd,
  output alsd_stat_t              stat,
  input  logic signed [SMP_W-1:0] sample,
  input  logic                    last,
  input  logic                    cfg_we,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  output logic                    silent,
  output logic [PEAK_W-1:0]       peak,
  output logic [THR_W-1:0]        variance,
  output logic [RMS_W-1:0]        rms_level,
  output logic signed [DB_W-1:0]  volume_db,
  output logic [RMS_W-1:0]        amplitude_pct,
  output logic [CNT_W-1:0]        buffer_length,
  output logic [THR_W-1:0]        cal_threshold,
  output logic signed [DB_W-1:0]  cal_noise_db,
  output logic [CB_W-1:0]         cal_count
);

  // configuration
  logic [THR_W-1:0]       thr;
  logic signed [DB_W-1:0] noise;
  logic                   cal_mode;

  // buffer accumulators
  logic [CNT_W-1:0]        cnt;
  logic [CNT_W-1:0]        cnt_next;
  logic signed [SUM_W-1:0] sum;
  logic [SQ_W-1:0]         sq;
  logic [PEAK_W-1:0]       pk;
  logic signed [31:0]      smp_sq;

  // calibration sums
  logic [CVS_W-1:0]        cvs;
  logic signed [CDB_W-1:0] cds;
  logic [CB_W-1:0]         cb;

  // working registers
  logic [PROD_W-1:0]     nsq;
  logic [PROD_W-1:0]     s1sq;
  logic [PROD_W-1:0]     amp_num;
  logic [DIV_D_W-1:0]    nn;
  logic [V_W-1:0]        v;
  logic [SQRT_X_W-1:0]   amp_q;
  logic [MUL_P_W-1:0]    lv;
  logic [E_W-1:0]        e;
  logic [31:0]           y;
  logic [FRAC_W-1:0]     frac;
  logic [63:0]           lprod;
  logic signed [DBP_W-1:0] dbprod;

  // unit connections
  logic [MUL_P_W-1:0]  mul_a;
  logic [MUL_B_W-1:0]  mul_b;
  logic [MUL_P_W-1:0]  mul_p;
  logic                mul_done;
  logic [DIV_N_W-1:0]  div_n;
  logic [DIV_D_W-1:0]  div_d;
  logic [DIV_N_W-1:0]  div_q;
  logic [DIV_D_W-1:0]  div_r;
  logic                div_done;
  logic [SQRT_X_W-1:0] sqrt_x;
  logic [SQRT_R_W-1:0] sqrt_root;
  logic                sqrt_done;

  // derived values
  logic [SUM_W-1:0]          sum_abs;
  logic [CDB_W-1:0]          cds_abs;
  logic [CVS_W+1:0]          cvs3;
  logic [32:0]               ysq;
  logic [LOG_W-1:0]          lval;
  logic signed [LOG_W:0]     ldiff;
  logic signed [DBP_W-25:0]  db_q;
  logic signed [DB_W+2:0]    db_n;
  logic signed [DB_W-1:0]    db_sat;
  logic [DB_W-1:0]           cdb_mag;

  always_comb begin
    cnt_next = cnt + 1'b1;
    smp_sq   = sample * sample;
    sum_abs  = sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
    cds_abs  = cds[CDB_W-1] ? CDB_W'(-cds) : CDB_W'(cds);
    cvs3     = {2'b00, cvs} + {1'b0, cvs, 1'b0};
    ysq      = lprod[63:31];
    lval     = {e, frac};
    ldiff    = $signed({1'b0, lval}) - (LOG_W + 1)'(LOG_REF);
    db_q     = dbprod[DBP_W-1:24];
    db_n     = (DB_W + 3)'(db_q) - (DB_W + 3)'(noise);
    if (db_n > (DB_W + 3)'(32767)) begin
      db_sat = 16'sh7fff;
    end else if (db_n < -(DB_W + 3)'(32768)) begin
      db_sat = 16'sh8000;
    end else begin
      db_sat = db_n[DB_W-1:0];
    end
    cdb_mag = div_q[DB_W-1:0] + DB_W'(div_r != '0);
  end

  // status back to the controller
  always_comb begin
    stat.buf_end   = last || (cnt_next == MAX_CNT);
    stat.mul_done  = mul_done;
    stat.div_done  = div_done;
    stat.sqrt_done = sqrt_done;
    stat.v_zero    = (v == '0);
    stat.norm_done = lv[MUL_P_W-1];
    stat.cb_zero   = (cb == '0);
  end

  // operand selection for the shared units
  always_comb begin
    case (cmd.mul_sel)
      MUL_NS: begin
        mul_a = MUL_P_W'(sq);
        mul_b = MUL_B_W'(cnt);
      end
      MUL_SS: begin
        mul_a = MUL_P_W'(sum_abs);
        mul_b = sum_abs;
      end
      MUL_NN: begin
        mul_a = MUL_P_W'(cnt);
        mul_b = MUL_B_W'(cnt);
      end
      MUL_AMP: begin
        mul_a = MUL_P_W'(sq);
        mul_b = AMP_SCALE;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    case (cmd.div_sel)
      DIV_VAR: begin
        div_n = DIV_N_W'(nsq - s1sq);
        div_d = nn;
      end
      DIV_V: begin
        div_n = DIV_N_W'({sq, {V_SHIFT{1'b0}}});
        div_d = DIV_D_W'(cnt);
      end
      DIV_AMP: begin
        div_n = DIV_N_W'(amp_num);
        div_d = DIV_D_W'({cnt, 10'b0});
      end
      DIV_THR: begin
        div_n = DIV_N_W'(cvs3);
        div_d = DIV_D_W'({cb, 1'b0});
      end
      DIV_CDB: begin
        div_n = DIV_N_W'(cds_abs);
        div_d = DIV_D_W'(cb);
      end
      default: begin
        div_n = '0;
        div_d = '0;
      end
    endcase
  end

  always_comb begin
    case (cmd.sqrt_sel)
      SQRT_RMS: sqrt_x = v[SQRT_X_W+15:16];
      SQRT_AMP: sqrt_x = amp_q;
      default:  sqrt_x = '0;
    endcase
  end

  alsd_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_done),
    .p     (mul_p)
  );

  alsd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .n     (div_n),
    .d     (div_d),
    .done  (div_done),
    .q     (div_q),
    .r     (div_r)
  );

  alsd_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.sqrt_start),
    .x     (sqrt_x),
    .done  (sqrt_done),
    .root  (sqrt_root)
  );

  // sample accumulation, cleared once the result is out
  always_ff @(posedge clk) begin
    if (rst || cmd.finish) begin
      cnt <= '0;
      sum <= '0;
      sq  <= '0;
      pk  <= '0;
    end else if (cmd.accept) begin
      cnt <= cnt_next;
      sum <= sum + SUM_W'(sample);
      sq  <= sq + SQ_W'(unsigned'(smp_sq));
      if (sample > $signed({1'b0, pk})) begin
        pk <= sample[PEAK_W-1:0];
      end
    end
  end

  // configuration registers and calibration sums
  always_ff @(posedge clk) begin
    if (rst) begin
      thr      <= THR_W'(1000);
      noise    <= '0;
      cal_mode <= 1'b0;
      cvs      <= '0;
      cds      <= '0;
      cb       <= '0;
    end else if (cfg_we) begin
      case (reg_idx_t'(cfg_index))
        REG_THRESHOLD: thr <= cfg_data;
        REG_NOISE:     noise <= cfg_data[DB_W-1:0];
        REG_CALIBRATE: begin
          cal_mode <= cfg_data[0];
          if (cfg_data[0]) begin
            cvs <= '0;
            cds <= '0;
            cb  <= '0;
          end
        end
        default: ;
      endcase
    end else if (cmd.cal_acc && cal_mode && (cb != CB_FULL)) begin
      cvs <= cvs + CVS_W'(variance);
      cds <= cds + CDB_W'(volume_db);
      cb  <= cb + 1'b1;
    end
  end

  // products and square roots land in their working registers
  always_ff @(posedge clk) begin
    if (mul_done) begin
      case (cmd.mul_sel)
        MUL_NS:  nsq     <= mul_p[PROD_W-1:0];
        MUL_SS:  s1sq    <= mul_p[PROD_W-1:0];
        MUL_NN:  nn      <= mul_p[DIV_D_W-1:0];
        MUL_AMP: amp_num <= mul_p[PROD_W-1:0];
        default: ;
      endcase
    end
    if (sqrt_done) begin
      case (cmd.sqrt_sel)
        SQRT_RMS: rms_level     <= sqrt_root;
        SQRT_AMP: amplitude_pct <= sqrt_root;
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cal_acc) begin
      cal_threshold <= '0;
      cal_noise_db  <= '0;
    end else if (div_done) begin
      case (cmd.div_sel)
        DIV_VAR: variance      <= div_q[THR_W-1:0];
        DIV_AMP: amp_q         <= div_q[SQRT_X_W-1:0];
        DIV_THR: cal_threshold <= div_q[THR_W-1:0];
        DIV_CDB: cal_noise_db  <= cds[CDB_W-1] ? DB_W'(-cdb_mag) : div_q[DB_W-1:0];
        default: ;
      endcase
    end
  end

  // level: normalise, log2 by repeated squaring, scale to dB
  always_ff @(posedge clk) begin
    if (div_done && (cmd.div_sel == DIV_V)) begin
      v  <= div_q[V_W-1:0];
      lv <= {div_q[V_W-1:0], {(MUL_P_W - V_W){1'b0}}};
      e  <= E_START;
    end else if (cmd.norm_shift) begin
      lv <= lv << 1;
      e  <= e - 1'b1;
    end
    if (cmd.log_init) begin
      y    <= lv[MUL_P_W-1:MUL_P_W-32];
      frac <= '0;
    end else if (cmd.log_adj) begin
      frac <= {frac[FRAC_W-2:0], ysq[32]};
      y    <= ysq[32] ? ysq[32:1] : ysq[31:0];
    end
    if (cmd.log_mul) begin
      lprod <= y * y;
    end
    if (cmd.db_mul) begin
      dbprod <= DBP_W'(ldiff) * DBP_W'(DB_PER_OCT);
    end
    if (cmd.db_fin) begin
      volume_db <= stat.v_zero ? 16'sh8000 : db_sat;
    end
  end

  // result fields taken from the buffer state
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      silent        <= variance < thr;
      peak          <= pk;
      buffer_length <= cnt;
      cal_count     <= cb;
    end
  end

endmodule

// ----- rtl/alsd_ctrl.sv -----
`timescale 1ns / 1ps

module alsd_ctrl import alsd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  alsd_stat_t stat,
  output alsd_cmd_t  cmd,
  output logic       busy,
  output logic       done
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_MUL_NS,
    S_MUL_SS,
    S_MUL_NN,
    S_DIV_VAR,
    S_DIV_V,
    S_SQRT_RMS,
    S_MUL_AMP,
    S_DIV_AMP,
    S_SQRT_AMP,
    S_NORM,
    S_LOG_MUL,
    S_LOG_ADJ,
    S_DB_MUL,
    S_DB_FIN,
    S_CAL_ACC,
    S_DIV_THR,
    S_DIV_CDB,
    S_FINISH
  } state_t;

  localparam int IW = $clog2(LOG_STEPS);

  state_t        state;
  logic          issued;
  logic [IW-1:0] iter;
  logic          in_mul;
  logic          in_div;
  logic          in_sqrt;
  logic          op_done;

  always_comb begin
    in_mul  = (state == S_MUL_NS) || (state == S_MUL_SS) ||
              (state == S_MUL_NN) || (state == S_MUL_AMP);
    in_div  = (state == S_DIV_VAR) || (state == S_DIV_V) || (state == S_DIV_AMP) ||
              (state == S_DIV_THR) || (state == S_DIV_CDB);
    in_sqrt = (state == S_SQRT_RMS) || (state == S_SQRT_AMP);
    op_done = issued && ((in_mul && stat.mul_done) || (in_div && stat.div_done) ||
                         (in_sqrt && stat.sqrt_done));
  end

  // commands
  always_comb begin
    cmd            = '0;
    cmd.accept     = (state == S_IDLE) && start;
    cmd.mul_start  = in_mul && !issued;
    cmd.div_start  = in_div && !issued && !((state == S_DIV_THR) && stat.cb_zero);
    cmd.sqrt_start = in_sqrt && !issued;
    cmd.norm_shift = (state == S_NORM) && !stat.v_zero && !stat.norm_done;
    cmd.log_init   = (state == S_NORM) && !stat.v_zero && stat.norm_done;
    cmd.log_mul    = (state == S_LOG_MUL);
    cmd.log_adj    = (state == S_LOG_ADJ);
    cmd.db_mul     = (state == S_DB_MUL);
    cmd.db_fin     = (state == S_DB_FIN);
    cmd.cal_acc    = (state == S_CAL_ACC);
    cmd.finish     = (state == S_FINISH);
    case (state)
      S_MUL_SS:  cmd.mul_sel = MUL_SS;
      S_MUL_NN:  cmd.mul_sel = MUL_NN;
      S_MUL_AMP: cmd.mul_sel = MUL_AMP;
      default:   cmd.mul_sel = MUL_NS;
    endcase
    case (state)
      S_DIV_V:   cmd.div_sel = DIV_V;
      S_DIV_AMP: cmd.div_sel = DIV_AMP;
      S_DIV_THR: cmd.div_sel = DIV_THR;
      S_DIV_CDB: cmd.div_sel = DIV_CDB;
      default:   cmd.div_sel = DIV_VAR;
    endcase
    cmd.sqrt_sel = (state == S_SQRT_AMP) ? SQRT_AMP : SQRT_RMS;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      issued <= 1'b0;
      iter   <= '0;
      busy   <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= (state == S_FINISH);
      if (cmd.mul_start || cmd.div_start || cmd.sqrt_start) begin
        issued <= 1'b1;
      end else if (op_done) begin
        issued <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (start && stat.buf_end) begin
            state <= S_MUL_NS;
            busy  <= 1'b1;
          end
        end
        S_MUL_NS:   if (op_done) state <= S_MUL_SS;
        S_MUL_SS:   if (op_done) state <= S_MUL_NN;
        S_MUL_NN:   if (op_done) state <= S_DIV_VAR;
        S_DIV_VAR:  if (op_done) state <= S_DIV_V;
        S_DIV_V:    if (op_done) state <= S_SQRT_RMS;
        S_SQRT_RMS: if (op_done) state <= S_MUL_AMP;
        S_MUL_AMP:  if (op_done) state <= S_DIV_AMP;
        S_DIV_AMP:  if (op_done) state <= S_SQRT_AMP;
        S_SQRT_AMP: if (op_done) state <= S_NORM;
        S_NORM: begin
          if (stat.v_zero) begin
            state <= S_DB_FIN;
          end else if (stat.norm_done) begin
            state <= S_LOG_MUL;
            iter  <= '0;
          end
        end
        S_LOG_MUL: state <= S_LOG_ADJ;
        S_LOG_ADJ: begin
          if (iter == IW'(LOG_STEPS - 1)) begin
            state <= S_DB_MUL;
          end else begin
            iter  <= iter + 1'b1;
            state <= S_LOG_MUL;
          end
        end
        S_DB_MUL:  state <= S_DB_FIN;
        S_DB_FIN:  state <= S_CAL_ACC;
        S_CAL_ACC: state <= S_DIV_THR;
        S_DIV_THR: begin
          if (!issued && stat.cb_zero) begin
            state <= S_FINISH;
          end else if (op_done) begin
            state <= S_DIV_CDB;
          end
        end
        S_DIV_CDB: if (op_done) state <= S_FINISH;
        S_FINISH: begin
          state <= S_IDLE;
          busy  <= 1'b0;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- rtl/audio_level_silence_detector_core.sv -----
`timescale 1ns / 1ps

// Audio level meter and silence gate. Samples are taken one per clock while
// busy is low (start high); the sample with last set, or the 4096th sample,
// closes the buffer. The block then raises busy while one bit-serial
// multiplier, divider (three or five quotients per buffer) and square-root
// unit work out variance, rms, dB level, amplitude and the calibration
// means. The finished beat appears on the result ports for exactly one cycle
// with done high, in the same cycle that busy falls, and must be taken then:
// there is no way to hold it. Configuration writes are taken at any edge
// with cfg_we high and belong in idle time between buffers.
module audio_level_silence_detector_core import alsd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic signed [SMP_W-1:0] sample,
  input  logic                    last,
  input  logic                    cfg_we,
  input  logic [IDX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  output logic                    done,
  output logic                    silent,
  output logic [PEAK_W-1:0]       peak,
  output logic [THR_W-1:0]        variance,
  output logic [RMS_W-1:0]        rms_level,
  output logic signed [DB_W-1:0]  volume_db,
  output logic [RMS_W-1:0]        amplitude_pct,
  output logic [CNT_W-1:0]        buffer_length,
  output logic [THR_W-1:0]        cal_threshold,
  output logic signed [DB_W-1:0]  cal_noise_db,
  output logic [CB_W-1:0]         cal_count
);

  alsd_cmd_t  cmd;
  alsd_stat_t stat;

  alsd_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  alsd_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .sample        (sample),
    .last          (last),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .silent        (silent),
    .peak          (peak),
    .variance      (variance),
    .rms_level     (rms_level),
    .volume_db     (volume_db),
    .amplitude_pct (amplitude_pct),
    .buffer_length (buffer_length),
    .cal_threshold (cal_threshold),
    .cal_noise_db  (cal_noise_db),
    .cal_count     (cal_count)
  );

endmodule

// ----- rtl/alsd_checker.sv -----
`timescale 1ns / 1ps

module alsd_checker import alsd_pkg::*; (
  input logic                    clk,
  input logic                    rst,
  input logic                    start,
  input logic                    busy,
  input logic                    done,
  input logic [CNT_W-1:0]        buffer_length
);

  // a result beat ends the busy period
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy && $past(busy))
    else $error("result beat without a preceding busy period");

  // busy only follows an accepted sample
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without an accepted sample");

  // one beat per buffer
  a_single_beat: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result beat repeated");

  // a finished buffer is never empty
  a_len: assert property (@(posedge clk) disable iff (rst)
    done |-> buffer_length != '0)
    else $error("empty buffer reported");

endmodule

bind audio_level_silence_detector_core alsd_checker u_alsd_checker (
  .clk           (clk),
  .rst           (rst),
  .start         (start),
  .busy          (busy),
  .done          (done),
  .buffer_length (buffer_length)
);

// ----- dv/audio_level_silence_detector_core_tb.sv -----
`timescale 1ns / 1ps

module audio_level_silence_detector_core_tb;
  import alsd_pkg::*;

  localparam logic [IDX_W-1:0] REG_SPARE = 2'd3;
  localparam int SETTLE_CYCLES = 700;
  localparam int CYCLE_LIMIT   = 20000000;

  typedef struct packed {
    logic                   silent;
    logic [PEAK_W-1:0]      peak;
    logic [THR_W-1:0]       variance;
    logic [RMS_W-1:0]       rms;
    logic signed [DB_W-1:0] db;
    logic [RMS_W-1:0]       amp;
    logic [CNT_W-1:0]       len;
    logic [THR_W-1:0]       cthr;
    logic signed [DB_W-1:0] cdb;
    logic [CB_W-1:0]        ccnt;
  } level_rec_t;

  typedef struct packed {
    logic signed [SMP_W-1:0] smp;
    logic                    lst;
  } sample_beat_t;

  logic clk, rst, start, busy, last, cfg_we, done;
  logic signed [SMP_W-1:0] sample;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;
  logic silent;
  logic [PEAK_W-1:0] peak;
  logic [THR_W-1:0] variance, cal_threshold;
  logic [RMS_W-1:0] rms_level, amplitude_pct;
  logic signed [DB_W-1:0] volume_db, cal_noise_db;
  logic [CNT_W-1:0] buffer_length;
  logic [CB_W-1:0] cal_count;

  audio_level_silence_detector_core uut (.*);

  // predictor state and register copies
  logic [THR_W-1:0]        thr_reg;
  logic signed [DB_W-1:0]  noise_reg;
  logic                    cal_mode;
  longint unsigned         acc_n, acc_sq, cal_var_sum;
  longint                  acc_sum, cal_db_sum;
  logic [PEAK_W-1:0]       acc_peak;
  int unsigned             cal_bufs;

  sample_beat_t pending_beats[$];
  level_rec_t   expected_levels[$];
  int errors = 0;
  int gap = 0;
  int cycles = 0;

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // append one beat to the end of the pending queue
  function automatic void add_beat(logic signed [SMP_W-1:0] smp, logic lst);
    sample_beat_t b;
    b.smp = smp;
    b.lst = lst;
    pending_beats.insert(pending_beats.size(), b);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned x);
    longint unsigned res = 0;
    longint unsigned bitv = 64'd1 << 62;
    while (bitv > x) bitv >>= 2;
    while (bitv != 0) begin
      if (x >= res + bitv) begin
        x -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // log2 in Q.16 by repeated squaring of the normalised mantissa
  function automatic longint log2_fix(longint unsigned v);
    int e = 63;
    longint unsigned y;
    longint frac = 0;
    while (v[e] == 1'b0) e--;
    y = (e >= 31) ? (v >> (e - 31)) : (v << (31 - e));
    for (int i = 0; i < 16; i++) begin
      y = (y * y) >> 31;
      frac = frac << 1;
      if (y >= (64'd1 << 32)) begin
        frac |= 1;
        y >>= 1;
      end
    end
    return longint'(e) * 65536 + frac;
  endfunction

  function automatic longint div_floor(longint a, longint d);
    if (a >= 0) return a / d;
    return -((-a + d - 1) / d);
  endfunction

  // fold one accepted beat in; returns 1 and the level record when a buffer closes
  function automatic bit absorb_sample(sample_beat_t b, output level_rec_t r);
    longint s = longint'(b.smp);
    longint unsigned sabs, var_q, v;
    longint db;
    acc_n++;
    acc_sum += s;
    acc_sq += longint'(s * s);
    if (s > longint'(acc_peak)) acc_peak = PEAK_W'(s);
    r = '0;
    if (!b.lst && acc_n < MAX_SAMPLES) return 0;
    sabs = (acc_sum < 0) ? -acc_sum : acc_sum;
    var_q = (acc_n * acc_sq - sabs * sabs) / (acc_n * acc_n);
    v = (2 * acc_sq * 65536) / acc_n;
    if (v == 0) begin
      db = -32768;
    end else begin
      db = (log2_fix(v) - LOG_REF) * DB_PER_OCT;
      db = (db >>> 24) - longint'(noise_reg);
      if (db > 32767) db = 32767;
      if (db < -32768) db = -32768;
    end
    if (cal_mode && cal_bufs < 65535) begin
      cal_var_sum += var_q;
      cal_db_sum += db;
      cal_bufs++;
    end
    r.silent = var_q < thr_reg;
    r.peak = acc_peak;
    r.variance = THR_W'(var_q);
    r.rms = RMS_W'(int_sqrt((2 * acc_sq) / acc_n));
    r.db = DB_W'(db);
    r.amp = RMS_W'(int_sqrt((2 * acc_sq * 625) / (acc_n * 1024)));
    r.len = CNT_W'(acc_n);
    if (cal_bufs != 0) begin
      r.cthr = THR_W'((3 * cal_var_sum) / (2 * longint'(cal_bufs)));
      r.cdb = DB_W'(div_floor(cal_db_sum, longint'(cal_bufs)));
    end
    r.ccnt = CB_W'(cal_bufs);
    acc_n = 0;
    acc_sum = 0;
    acc_sq = 0;
    acc_peak = '0;
    return 1;
  endfunction

  // driver: one beat in flight, random gaps after some beats
  always @(posedge clk) begin
    level_rec_t r;
    sample_beat_t b;
    if (rst) begin
      start <= 1'b0;
    end else if (start && busy) begin
      start <= 1'b1;
    end else begin
      if (start && absorb_sample('{sample, last}, r))
        expected_levels.insert(expected_levels.size(), r);
      if (gap > 0) begin
        gap--;
        start <= 1'b0;
      end else if (pending_beats.size() > 0) begin
        b = pending_beats.pop_front();
        sample <= b.smp;
        last <= b.lst;
        start <= 1'b1;
        case ($urandom_range(0, 9))
          0:       gap = $urandom_range(10, 60);
          1, 2, 3: gap = $urandom_range(1, 3);
          default: gap = 0;
        endcase
      end else begin
        start <= 1'b0;
      end
    end
  end

  task automatic report_mismatch(string what, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // monitor: every done beat against the oldest expected level record
  always @(posedge clk) begin
    level_rec_t w;
    if (!rst && done) begin
      if (expected_levels.size() == 0) begin
        report_mismatch("unexpected result beat", 1, 0);
      end else begin
        w = expected_levels.pop_front();
        if (silent !== w.silent) report_mismatch("silent", silent, w.silent);
        if (peak !== w.peak) report_mismatch("peak", peak, w.peak);
        if (variance !== w.variance) report_mismatch("variance", variance, w.variance);
        if (rms_level !== w.rms) report_mismatch("rms_level", rms_level, w.rms);
        if (volume_db !== w.db) report_mismatch("volume_db", volume_db, w.db);
        if (amplitude_pct !== w.amp) report_mismatch("amplitude_pct", amplitude_pct, w.amp);
        if (buffer_length !== w.len) report_mismatch("buffer_length", buffer_length, w.len);
        if (cal_threshold !== w.cthr)
          report_mismatch("cal_threshold", cal_threshold, w.cthr);
        if (cal_noise_db !== w.cdb) report_mismatch("cal_noise_db", cal_noise_db, w.cdb);
        if (cal_count !== w.ccnt) report_mismatch("cal_count", cal_count, w.ccnt);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_THRESHOLD: thr_reg = data;
      REG_NOISE:     noise_reg = data[DB_W-1:0];
      REG_CALIBRATE: begin
        cal_mode = data[0];
        if (data[0]) begin
          cal_var_sum = 0;
          cal_db_sum = 0;
          cal_bufs = 0;
        end
      end
      default: ;
    endcase
  endtask

  // block until every beat is taken and every result has come back
  task automatic drain;
    @(posedge clk);
    while (pending_beats.size() > 0 || start || busy || expected_levels.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [SMP_W-1:0] pick_sample(int style, logic signed [SMP_W-1:0] k);
    case (style)
      0:       return '0;
      1:       return SMP_W'($signed($urandom_range(0, 16)) - 8);
      2:       return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      3:       return k;
      default: return SMP_W'($urandom);
    endcase
  endfunction

  task automatic queue_buffer(int len, int style);
    logic signed [SMP_W-1:0] k = SMP_W'($urandom);
    for (int i = 1; i <= len; i++)
      add_beat(pick_sample(style, k), i == len);
  endtask

  task automatic queue_random(int budget);
    int len;
    while (budget > 0) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 80) : $urandom_range(1, 16);
      queue_buffer(len, $urandom_range(0, 5));
      budget -= len;
    end
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    sample = '0;
    last = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_THRESHOLD;
    cfg_data = '0;
    thr_reg = 1000;
    noise_reg = '0;
    cal_mode = 1'b0;
    acc_n = 0; acc_sum = 0; acc_sq = 0; acc_peak = '0;
    cal_var_sum = 0; cal_db_sum = 0; cal_bufs = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, all-zero buffer, constant buffer, mixed signs
    add_beat(16'sh8000, 1'b1);
    add_beat(16'sh7fff, 1'b1);
    add_beat(16'sh0000, 1'b1);
    queue_buffer(4, 0);
    add_beat(16'sh7fff, 1'b0);
    add_beat(16'sh8000, 1'b1);
    add_beat(16'sh0001, 1'b0);
    add_beat(-16'sd1, 1'b1);
    queue_buffer(5, 3);
    queue_buffer(6, 2);
    drain();
    // buffer full closes without last
    for (int i = 0; i < MAX_SAMPLES; i++) add_beat(SMP_W'($urandom), 1'b0);
    queue_random(200);
    drain();

    // threshold at zero and at 2^30, noise floor at its extremes
    write_reg(REG_THRESHOLD, '0);
    write_reg(REG_NOISE, CFG_W'(16'h8000));
    queue_random(200);
    drain();
    write_reg(REG_THRESHOLD, CFG_W'(32'h4000_0000));
    write_reg(REG_NOISE, CFG_W'(16'h7fff));
    queue_random(200);
    drain();

    // calibration: clear and gather, leave mode keeping sums, reenter
    write_reg(REG_NOISE, CFG_W'(16'hfd00));
    write_reg(REG_CALIBRATE, CFG_W'(1));
    queue_random(200);
    drain();
    write_reg(REG_CALIBRATE, CFG_W'(0));
    write_reg(REG_THRESHOLD, CFG_W'($urandom_range(0, 200000)));
    queue_random(150);
    drain();
    write_reg(REG_SPARE, CFG_W'($urandom));
    write_reg(REG_CALIBRATE, CFG_W'(1));
    write_reg(REG_NOISE, CFG_W'($urandom));
    queue_random(200);
    drain();

    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- audio_level_silence_detector_core.f -----
rtl/alsd_pkg.sv
rtl/alsd_mul.sv
rtl/alsd_div.sv
rtl/alsd_sqrt.sv
rtl/alsd_dp.sv
rtl/alsd_ctrl.sv
rtl/audio_level_silence_detector_core.sv
rtl/alsd_checker.sv
dv/audio_level_silence_detector_core_tb.sv
